@@ design/ghal_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ghal_pkg - shared types and constants
// Handle layout, slot table geometry, operation and status codes.
// ----------------------------------------------------------------------------
package ghal_pkg;

  localparam int SLOTS    = 64;
  localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int HANDLE_W = 64;
  localparam int TAG_W    = 8;
  localparam int GEN_W    = 32;
  localparam int SFIELD_W = 24;
  localparam int KIND_LSB = 56;
  localparam int GEN_LSB  = 24;
  localparam int REF_W    = 32;
  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W   = $clog2(QDEPTH + 1);

  localparam logic [GEN_W-1:0] GEN_MAX   = '1;
  localparam logic [REF_W-1:0] REF_MAX   = '1;
  localparam logic [TAG_W-1:0] TAG_RESET = TAG_W'(1);

  typedef enum logic [1:0] {
    OP_CREATE  = 2'd0,
    OP_RETAIN  = 2'd1,
    OP_RELEASE = 2'd2,
    OP_UNKNOWN = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_INVALID    = 2'd1,
    ST_OVERFLOW   = 2'd2,
    ST_ALLOC_FAIL = 2'd3
  } status_e;

  typedef enum logic {
    BK_READ = 1'b0,
    BK_EXEC = 1'b1
  } bk_state_e;

  // Classified command handed from the front to the back
  typedef struct packed {
    op_e               op;
    logic [SLOT_W-1:0] slot;
    logic [GEN_W-1:0]  gen;
    logic              pre_ok;  // fixed-field checks of the handle passed
  } cmd_t;

endpackage
`default_nettype wire

@@ design/ghal_req_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ghal_req_if - request channel
// Valid/ready channel carrying one operation item.
// ----------------------------------------------------------------------------
interface ghal_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [63:0] handle;

  modport source (output valid, output kind, output handle, input ready);
  modport sink   (input valid, input kind, input handle, output ready);
endinterface
`default_nettype wire

@@ design/ghal_rsp_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ghal_rsp_if - response channel
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface ghal_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [63:0] new_handle;

  modport source (output valid, output status, output new_handle, input ready);
  modport sink   (input valid, input status, input new_handle, output ready);
endinterface
`default_nettype wire

@@ design/ghal_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ghal_ram - generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ghal_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                          wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output      logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

@@ design/ghal_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ghal_front - request classifier and command queue
// Checks the fixed handle fields and queues classified commands.
// ----------------------------------------------------------------------------
module ghal_front
  import ghal_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [TAG_W-1:0] tag_i,
  ghal_req_if.sink              req_i,
  output      logic             q_valid_o,
  output      cmd_t             q_cmd_o,
  input  wire logic             q_pop_i
);

  cmd_t              cmd;
  logic [SFIELD_W-1:0] sfield;
  logic              push;
  cmd_t              ent_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;

  // Classification: everything that does not need the slot tables
  always_comb begin
    sfield      = req_i.handle[SFIELD_W-1:0];
    cmd.op      = op_e'(req_i.kind);
    cmd.gen     = req_i.handle[GEN_LSB +: GEN_W];
    cmd.slot    = SLOT_W'(sfield - SFIELD_W'(1));
    cmd.pre_ok  = (req_i.handle[KIND_LSB +: TAG_W] == tag_i)
               && (sfield != '0) && (cmd.gen != '0)
               && (sfield <= SFIELD_W'(SLOTS));
  end

  assign req_i.ready = (count_q != QCNT_W'(QDEPTH));
  assign push        = req_i.valid && req_i.ready;
  assign q_valid_o   = (count_q != '0);
  assign q_cmd_o     = ent_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (q_pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    if (push && !q_pop_i) begin
      count_d = count_q + QCNT_W'(1);
    end else if (!push && q_pop_i) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_ptr_q] <= cmd;
    end
  end

  // A pop only ever takes an occupied entry
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_i |-> (count_q != '0))
    else $error("command queue popped while empty");

endmodule
`default_nettype wire

@@ design/ghal_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ghal_back - slot table engine
// Read-modify-write of one slot entry per command, result register.
// ----------------------------------------------------------------------------
module ghal_back
  import ghal_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [TAG_W-1:0] tag_i,
  input  wire logic             q_valid_i,
  input  wire cmd_t             q_cmd_i,
  output      logic             q_pop_o,
  ghal_rsp_if.source            rsp_o
);

  bk_state_e         state_q, state_d;
  cmd_t              cmd_q;
  cmd_t              pop_cmd;
  logic              alloc_ok_q;
  logic [SLOTS-1:0]  in_use_q, in_use_d;
  logic [SLOTS-1:0]  exhausted_q, exhausted_d;
  logic [SLOTS-1:0]  gen_valid_q, gen_valid_d;
  logic [SLOTS-1:0]  free_slots;
  logic              ff_found;
  logic [SLOT_W-1:0] ff_idx;
  logic [SLOT_W-1:0] raddr;
  logic [GEN_W-1:0]  gen_rdata, gen_cur, gen_wdata;
  logic [REF_W-1:0]  ref_rdata, ref_wdata;
  logic              gen_we, ref_we;
  logic              handle_ok, out_load;
  status_e           status_d, out_status_q;
  logic [HANDLE_W-1:0] handle_d, out_handle_q;
  logic              out_valid_q;

  assign free_slots = ~in_use_q & ~exhausted_q;

  // Lowest free slot
  always_comb begin
    ff_found = 1'b0;
    ff_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (free_slots[i]) begin
        ff_found = 1'b1;
        ff_idx   = SLOT_W'(i);
      end
    end
  end

  // Create works on the slot found by the search, not the handle's field
  always_comb begin
    pop_cmd = q_cmd_i;
    if (q_cmd_i.op == OP_CREATE) begin
      pop_cmd.slot = ff_idx;
    end
  end

  assign raddr = pop_cmd.slot;

  ghal_ram #(.WIDTH(GEN_W), .DEPTH(SLOTS)) u_gen_ram (
    .clk_i   (clk_i),
    .we_i    (gen_we),
    .waddr_i (cmd_q.slot),
    .wdata_i (gen_wdata),
    .raddr_i (raddr),
    .rdata_o (gen_rdata)
  );

  ghal_ram #(.WIDTH(REF_W), .DEPTH(SLOTS)) u_ref_ram (
    .clk_i   (clk_i),
    .we_i    (ref_we),
    .waddr_i (cmd_q.slot),
    .wdata_i (ref_wdata),
    .raddr_i (raddr),
    .rdata_o (ref_rdata)
  );

  // Never-written generation entries read as one
  assign gen_cur   = gen_valid_q[cmd_q.slot] ? gen_rdata : GEN_W'(1);
  assign handle_ok = cmd_q.pre_ok && in_use_q[cmd_q.slot]
                  && (gen_cur == cmd_q.gen) && (ref_rdata != '0);

  always_comb begin
    state_d     = state_q;
    q_pop_o     = 1'b0;
    out_load    = 1'b0;
    in_use_d    = in_use_q;
    exhausted_d = exhausted_q;
    gen_valid_d = gen_valid_q;
    gen_we      = 1'b0;
    gen_wdata   = gen_cur + GEN_W'(1);
    ref_we      = 1'b0;
    ref_wdata   = REF_W'(1);
    status_d    = ST_INVALID;
    handle_d    = '0;
    unique case (state_q)
      BK_READ: begin
        if (q_valid_i && (!out_valid_q || rsp_o.ready)) begin
          q_pop_o = 1'b1;
          state_d = BK_EXEC;
        end
      end
      BK_EXEC: begin
        out_load = 1'b1;
        state_d  = BK_READ;
        unique case (cmd_q.op)
          OP_CREATE: begin
            if (alloc_ok_q) begin
              in_use_d[cmd_q.slot] = 1'b1;
              ref_we    = 1'b1;
              ref_wdata = REF_W'(1);
              status_d  = ST_OK;
              handle_d  = {tag_i, gen_cur,
                           SFIELD_W'(cmd_q.slot) + SFIELD_W'(1)};
            end else begin
              status_d = ST_ALLOC_FAIL;
            end
          end
          OP_RETAIN: begin
            if (handle_ok) begin
              if (ref_rdata == REF_MAX) begin
                status_d = ST_OVERFLOW;
              end else begin
                ref_we    = 1'b1;
                ref_wdata = ref_rdata + REF_W'(1);
                status_d  = ST_OK;
              end
            end
          end
          OP_RELEASE: begin
            if (handle_ok) begin
              ref_we    = 1'b1;
              ref_wdata = ref_rdata - REF_W'(1);
              status_d  = ST_OK;
              if (ref_rdata == REF_W'(1)) begin
                in_use_d[cmd_q.slot] = 1'b0;
                if (gen_cur != GEN_MAX) begin
                  gen_we                  = 1'b1;
                  gen_valid_d[cmd_q.slot] = 1'b1;
                  if (gen_wdata == GEN_MAX) begin
                    exhausted_d[cmd_q.slot] = 1'b1;
                  end
                end
              end
            end
          end
          default: begin
            status_d = ST_INVALID;
          end
        endcase
      end
      default: begin
        state_d = BK_READ;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_READ;
      in_use_q    <= '0;
      exhausted_q <= '0;
      gen_valid_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      in_use_q    <= in_use_d;
      exhausted_q <= exhausted_d;
      gen_valid_q <= gen_valid_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cmd_q      <= pop_cmd;
      alloc_ok_q <= ff_found;
    end
    if (out_load) begin
      out_status_q <= status_d;
      out_handle_q <= handle_d;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.status     = out_status_q;
  assign rsp_o.new_handle = out_handle_q;

  // The result register is always free when a command executes
  a_exec_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_EXEC) |-> !out_valid_q)
    else $error("result register busy during execute");

  // Execute is never held: the state after it is always read
  a_exec_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_EXEC) |=> (state_q == BK_READ))
    else $error("execute state held");

  // A retired slot is never in use
  a_retired_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_use_q & exhausted_q) == '0)
    else $error("exhausted slot marked in use");

endmodule
`default_nettype wire

@@ design/generational_handle_allocator.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Path: an accepted item is written to the command queue, popped into the command
//   register while the RAMs read its slot entry, then executed into the result register.
// The back takes one item at a time, as a read-modify-write of one slot entry
//   through the registered read port of the generation and refcount RAMs.
// Reset: slot flags clear at once; unwritten generations read as 1 through per-slot
//   valid bits and a refcount is only read once its create has written it. Kind tag is 1.
// ----------------------------------------------------------------------------
// generational_handle_allocator - reference-counted generational handle table
// Create, retain and release of 64-bit handles over a table of slots.
// ----------------------------------------------------------------------------
module generational_handle_allocator
  import ghal_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [TAG_W-1:0] cfg_wdata_i,
  ghal_req_if.sink              req_i,
  ghal_rsp_if.source            rsp_o
);

  // Kind tag written into new handles and expected in handles presented
  logic [TAG_W-1:0] tag_q;
  logic             q_valid;
  logic             q_pop;
  cmd_t             q_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= TAG_RESET;
    end else if (cfg_we_i) begin
      tag_q <= cfg_wdata_i;
    end
  end

  // Front: takes items, checks the fields that need no table lookup and
  // queues a classified command. It keeps accepting while the back works, until the queue is full.
  ghal_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .tag_i     (tag_q),
    .req_i     (req_i),
    .q_valid_o (q_valid),
    .q_cmd_o   (q_cmd),
    .q_pop_i   (q_pop)
  );

  // Back: one command at a time - read the slot entry in the pop cycle,
  // finish validation, update the tables and load the result register next.
  ghal_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .tag_i     (tag_q),
    .q_valid_i (q_valid),
    .q_cmd_i   (q_cmd),
    .q_pop_o   (q_pop),
    .rsp_o     (rsp_o)
  );

endmodule
`default_nettype wire
